### hw/rtl/dns_ptr_query_builder_macros.svh
// Assertion macros shared by the reverse-lookup query builder RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef DNS_PTR_QUERY_BUILDER_MACROS_SVH
`define DNS_PTR_QUERY_BUILDER_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define DPQB_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define DPQB_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/dpqb_pkg.sv
// Shared types, constants and label encoders for the reverse-lookup query builder.
// Depends on nothing; imported by the top level.
package dpqb_pkg;

   // Request layout as stored in the queue memory: {lower, upper, is_ipv6, rd, id}
   localparam int ID_W   = 16;
   localparam int ADDR_W = 64;
   localparam int REQ_W  = ID_W + 1 + 1 + ADDR_W + ADDR_W;

   // Default queue depth in requests
   localparam int QUEUE_DEPTH = 4;

   // Message geometry
   localparam int MSG_BYTES = 90;
   localparam int MSG_BITS  = 8 * MSG_BYTES;
   localparam int HDR_BITS  = 96;
   localparam int V6_NAME_BITS = 512;
   localparam int V4_AREA_BYTES = 34;
   localparam int V4_AREA_BITS  = 8 * V4_AREA_BYTES;
   localparam int V4_FIXED_BYTES = 30;          // header plus tail and type/class

   localparam logic [5:0] MSG_WORDS_V6 = 6'd45;

   // byte_count codes
   localparam logic [1:0] BYTES_ONE = 2'd1;
   localparam logic [1:0] BYTES_TWO = 2'd2;

   // Name tails including the root byte, type PTR and class IN
   localparam logic [111:0] V6_TAIL =
      {8'd3, "ip6", 8'd4, "arpa", 8'h00, 8'h00, 8'h0c, 8'h00, 8'h01};
   localparam logic [143:0] V4_TAIL =
      {8'd7, "in-addr", 8'd4, "arpa", 8'h00, 8'h00, 8'h0c, 8'h00, 8'h01};

   // One decimal label: length byte plus digits, left aligned in 32 bits
   typedef struct packed {
      logic [2:0]  len;
      logic [31:0] bytes;
   } label_type;

   // Lower-case hex character of a nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] val;
      val = {4'b0, nib};
      if (nib < 4'd10) begin
         return 8'h30 + val;
      end
      return 8'h57 + val;
   endfunction

   // ASCII digit of a value below ten
   function automatic logic [7:0] dec_char(input logic [3:0] dig);
      return 8'h30 + {4'b0, dig};
   endfunction

   // Decimal label of one address byte, no leading zeros
   function automatic label_type dec_label(input logic [7:0] v);
      logic [1:0]  h;
      logic [7:0]  hund;
      logic [6:0]  r;
      logic [17:0] prod;
      logic [3:0]  t;
      logic [3:0]  u;
      label_type   lab;
      if (v >= 8'd200) begin
         h = 2'd2;
         hund = 8'd200;
      end else if (v >= 8'd100) begin
         h = 2'd1;
         hund = 8'd100;
      end else begin
         h = 2'd0;
         hund = 8'd0;
      end
      r = 7'(v - hund);
      // tens by reciprocal multiply, exact for values below 100
      prod = 18'(r) * 18'd205;
      t = 4'(prod >> 11);
      u = 4'(r - 7'({3'b0, t} * 7'd10));
      if (h != 2'd0) begin
         lab.len = 3'd4;
         lab.bytes = {8'd3, dec_char({2'b0, h}), dec_char(t), dec_char(u)};
      end else if (t != 4'd0) begin
         lab.len = 3'd3;
         lab.bytes = {8'd2, dec_char(t), dec_char(u), 8'h00};
      end else begin
         lab.len = 3'd2;
         lab.bytes = {8'd1, dec_char(u), 16'h0000};
      end
      return lab;
   endfunction

endpackage

### hw/rtl/dns_ptr_query_builder.sv
// Top level of the reverse-lookup (PTR) query builder: request queue in RAM,
// message assembly and word output. Depends on dpqb_pkg, dpqb_ram and the macro header.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: id, rd, address; req_tuser: is_ipv6
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: word; rsp_tuser: byte_count; rsp_tlast
//
// One message word leaves per cycle while rsp_tready is high: an IPv6 message is 45 words,
// an IPv4 message 19 to 23, paced by the 16-bit output port. Requests queue in a RAM of
// DEPTH entries; the first word appears once its request has passed the queue write, the
// RAM read and the message load, and a staged next message loads behind the last word of
// the current one without a gap. Reset empties the queue. A stalled output holds its word;
// the request side stalls only when the queue is full.
`include "dns_ptr_query_builder_macros.svh"

module dns_ptr_query_builder
   import dpqb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] query_id, [16] recursion_desired, [80:17] address_upper,
   // [144:81] address_lower, [151:145] zero
   input  logic [151:0] req_tdata,
   // [0] is_ipv6
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] data_word
   output logic [15:0]  rsp_tdata,
   // [1:0] byte_count
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Queue control
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             staged_ff, staged_in;
   logic             push, rd_issue, load, rsp_take;
   logic [REQ_W-1:0] wr_req, rd_req;

   // Output message
   logic [MSG_BITS-1:0] msg_ff, msg_in;
   logic [5:0]          words_ff, words_in;
   logic                odd_ff, odd_in;

   // Assembled message from the staged request
   logic [MSG_BITS-1:0] built_msg;
   logic [5:0]          built_words;
   logic                built_odd;
   logic                built_v6;

   // Fields of the staged request
   logic [ID_W-1:0]   st_id;
   logic              st_rd;
   logic [ADDR_W-1:0] st_upper, st_lower;

   assign wr_req = {req_tdata[144:81], req_tdata[80:17], req_tuser, req_tdata[16:0]};
   assign {st_lower, st_upper, built_v6, st_rd, st_id} = rd_req;

   // Handshake and queue control
   assign req_tready = (count_ff != CNT_W'(DEPTH));
   assign push       = req_tvalid && req_tready;
   assign rsp_tvalid = (words_ff != 6'd0);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign load       = staged_ff && ((words_ff == 6'd0) || ((words_ff == 6'd1) && rsp_tready));
   assign rd_issue   = (count_ff != CNT_W'(0)) && (!staged_ff || load);

   dpqb_ram #(
      .WIDTH (REQ_W),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_req),
      .rd_en   (rd_issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_req)
   );

   // Assemble the whole message from the staged request
   always_comb begin
      logic [V6_NAME_BITS-1:0] v6_name;
      logic [V4_AREA_BITS-1:0] v4_area;
      logic [HDR_BITS-1:0]     hdr;
      logic [2*ADDR_W-1:0]     addr;
      logic [4:0]              off;
      logic [7:0]              b;
      label_type               lab;
      hdr = {st_id, 7'b0, st_rd, 8'h00, 8'h00, 8'h01, 48'h0};
      addr = {st_upper, st_lower};
      v6_name = '0;
      v4_area = '0;
      off = 5'd0;
      // IPv6: nibble labels from the last address byte back
      for (int i = 0; i < 16; i++) begin
         b = addr[8*i +: 8];
         v6_name[V6_NAME_BITS-1-32*i -: 32] = {8'd1, hex_char(b[3:0]), 8'd1, hex_char(b[7:4])};
      end
      // IPv4: decimal labels from the last address byte back, packed by running offset
      for (int k = 0; k < 4; k++) begin
         lab = dec_label(st_upper[32+8*k +: 8]);
         v4_area = v4_area | ({lab.bytes, (V4_AREA_BITS-32)'(0)} >> {off, 3'b0});
         off = off + 5'(lab.len);
      end
      v4_area = v4_area | ({V4_TAIL, (V4_AREA_BITS-144)'(0)} >> {off, 3'b0});
      if (built_v6) begin
         built_msg   = {hdr, v6_name, V6_TAIL};
         built_words = MSG_WORDS_V6;
         built_odd   = 1'b0;
      end else begin
         built_msg   = {hdr, v4_area, (MSG_BITS-HDR_BITS-V4_AREA_BITS)'(0)};
         built_words = 6'((6'(V4_FIXED_BYTES) + {1'b0, off} + 6'd1) >> 1);
         built_odd   = off[0];
      end
   end

   // Next-state logic
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? AW'(0) : AW'(wr_ptr_ff + AW'(1));
      end
      if (rd_issue) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? AW'(0) : AW'(rd_ptr_ff + AW'(1));
      end
      count_in = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(rd_issue));
      // hold staged data until loaded; refill on each read
      if (rd_issue) begin
         staged_in = 1'b1;
      end else if (load) begin
         staged_in = 1'b0;
      end else begin
         staged_in = staged_ff;
      end
      // load a new message, or advance one word on each taken word
      msg_in   = msg_ff;
      words_in = words_ff;
      odd_in   = odd_ff;
      if (load) begin
         msg_in   = built_msg;
         words_in = built_words;
         odd_in   = built_odd;
      end else if (rsp_take) begin
         msg_in   = {msg_ff[MSG_BITS-17:0], 16'h0000};
         words_in = words_ff - 6'd1;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         staged_ff <= 1'b0;
         words_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         staged_ff <= staged_in;
         words_ff  <= words_in;
      end
      msg_ff <= msg_in;
      odd_ff <= odd_in;
   end

   // Output word
   assign rsp_tdata = msg_ff[MSG_BITS-1 -: 16];
   assign rsp_tlast = (words_ff == 6'd1);
   assign rsp_tuser = (rsp_tlast && odd_ff) ? BYTES_ONE : BYTES_TWO;

   // Checks
   `DPQB_CHECK(a_count_range, clock, reset, 1'b1, (count_ff <= CNT_W'(DEPTH)), "queue count above depth")
   `DPQB_CHECK_NEXT(a_read_stages, clock, reset, rd_issue, staged_ff, "queue read not staged")
   `DPQB_CHECK_NEXT(a_v6_length, clock, reset, (load && built_v6), (words_ff == MSG_WORDS_V6), "IPv6 message length wrong")
   `DPQB_CHECK(a_short_is_last, clock, reset, (rsp_tvalid && (rsp_tuser == BYTES_ONE)), rsp_tlast, "short word before message end")

endmodule

### hw/rtl/dpqb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds queued requests for the query builder; depends on nothing.
module dpqb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/tb.sv
// Self-checking bench for dns_ptr_query_builder: drives query requests and checks every
// message word against a local predictor of the reverse-lookup query format.
// Depends on dpqb_pkg and the dns_ptr_query_builder RTL.
module tb
   import dpqb_pkg::*;
();

   localparam int QUERY_COUNT  = 320;
   localparam int QUIET_TAIL   = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 600;
   localparam int HOLD_AFTER   = 60;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [15:0] FLAGS_RD  = 16'h0100;
   localparam logic [15:0] FLAGS_NONE = 16'h0000;
   localparam logic [15:0] QDCOUNT   = 16'h0001;
   localparam logic [15:0] QTYPE_PTR = 16'h000c;
   localparam logic [15:0] QCLASS_IN = 16'h0001;
   localparam logic [7:0]  ROOT_BYTE = 8'h00;

   typedef struct packed {
      logic [15:0] id;
      logic        rd;
      logic        is_ipv6;
      logic [63:0] upper;
      logic [63:0] lower;
   } ptr_query_type;

   typedef struct {
      logic [15:0] word;
      logic [1:0]  nbytes;
      logic        is_last;
   } msg_word_type;

   // Builds the expected message words of each query and matches arriving words
   class query_message_model_type;
      msg_word_type pending_words[$];
      logic [7:0]   msg_bytes[$];
      int           mismatch_count = 0;

      task report(input string what);
         $display("MISMATCH: %s", what);
         mismatch_count++;
      endtask

      function void put_word16(input logic [15:0] w);
         msg_bytes.push_back(w[15:8]);
         msg_bytes.push_back(w[7:0]);
      endfunction

      // Append one length-prefixed label
      function void put_label(input string s);
         msg_bytes.push_back(8'(s.len()));
         for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
      endfunction

      function void note_query(input ptr_query_type q);
         logic [127:0] addr;
         logic [7:0]   b;
         int           nbytes;
         int           nwords;
         msg_word_type w;
         addr = {q.upper, q.lower};
         msg_bytes.delete();
         // header: id, flags, one question, three empty counts
         put_word16(q.id);
         put_word16(q.rd ? FLAGS_RD : FLAGS_NONE);
         put_word16(QDCOUNT);
         put_word16(16'h0000);
         put_word16(16'h0000);
         put_word16(16'h0000);
         // reversed name, last address byte first
         if (q.is_ipv6) begin
            for (int i = 15; i >= 0; i--) begin
               b = addr[127 - 8 * i -: 8];
               put_label($sformatf("%h", b[3:0]));
               put_label($sformatf("%h", b[7:4]));
            end
            put_label("ip6");
         end else begin
            for (int i = 3; i >= 0; i--) begin
               b = addr[127 - 8 * i -: 8];
               put_label($sformatf("%0d", b));
            end
            put_label("in-addr");
         end
         put_label("arpa");
         msg_bytes.push_back(ROOT_BYTE);
         put_word16(QTYPE_PTR);
         put_word16(QCLASS_IN);
         // pack into words, an odd last byte goes high
         nbytes = msg_bytes.size();
         nwords = (nbytes + 1) / 2;
         for (int k = 0; k < nwords; k++) begin
            w.nbytes = (2 * k + 1 < nbytes) ? BYTES_TWO : BYTES_ONE;
            w.word = {msg_bytes[2 * k], (w.nbytes == BYTES_TWO) ? msg_bytes[2 * k + 1] : 8'h00};
            w.is_last = (k == nwords - 1);
            pending_words.push_back(w);
         end
      endfunction

      task check_word(input logic [15:0] word, input logic [1:0] nbytes, input logic is_last);
         msg_word_type w;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected word %h bytes %0d last %b", word, nbytes, is_last));
         end else begin
            w = pending_words.pop_front();
            if (word !== w.word)
               report($sformatf("data word %h, predicted %h", word, w.word));
            if (nbytes !== w.nbytes)
               report($sformatf("byte count %0d, predicted %0d (word %h)", nbytes, w.nbytes,
                                w.word));
            if (is_last !== w.is_last)
               report($sformatf("last flag %b, predicted %b (word %h)", is_last, w.is_last,
                                w.word));
         end
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   query_message_model_type sb = new();
   int queries_sent = 0;
   int idle_pct = 0;
   bit quiet_tail = 1'b0;

   dns_ptr_query_builder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic ptr_query_type mk_query(input logic [15:0] id, input logic rd,
                                              input logic v6, input logic [63:0] upper,
                                              input logic [63:0] lower);
      ptr_query_type q;
      q.id = id;
      q.rd = rd;
      q.is_ipv6 = v6;
      q.upper = upper;
      q.lower = lower;
      return q;
   endfunction

   // Random query; IPv4 bytes lean toward each label length
   function automatic ptr_query_type random_query();
      ptr_query_type q;
      logic [7:0] b;
      q.id = 16'($urandom);
      q.rd = 1'($urandom);
      q.is_ipv6 = 1'($urandom);
      q.upper = {$urandom, $urandom};
      q.lower = {$urandom, $urandom};
      if (!q.is_ipv6) begin
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
               0: b = 8'($urandom_range(0, 9));
               1: b = 8'($urandom_range(10, 99));
               2: b = 8'($urandom_range(100, 255));
               default: b = 8'($urandom);
            endcase
            q.upper[63 - 8 * i -: 8] = b;
         end
      end
      return q;
   endfunction

   // Offer one request, with an optional gap first, and hold it until taken
   task automatic offer_query(input ptr_query_type q);
      int gap;
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'b0, q.lower, q.upper, q.rd, q.id};
      req_tuser  <= q.is_ipv6;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_query(q);
      queries_sent++;
   endtask

   // Stop offering until every predicted word has come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      ptr_query_type directed[$];
      int random_count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // header extremes, every label length, odd and even message lengths
      directed.push_back(mk_query(16'h0000, 1'b0, 1'b1, 64'h0, 64'h0));
      directed.push_back(mk_query(16'hffff, 1'b1, 1'b1, '1, '1));
      directed.push_back(mk_query(16'h1234, 1'b1, 1'b1, 64'h0123456789abcdef,
                                  64'hfedcba9876543210));
      directed.push_back(mk_query(16'h00ff, 1'b0, 1'b1, '1, 64'h0));
      directed.push_back(mk_query(16'hff00, 1'b1, 1'b1, 64'h20010db800000000,
                                  64'h00000000deadbeef));
      directed.push_back(mk_query(16'h0001, 1'b0, 1'b0, 64'h0, 64'h0));
      directed.push_back(mk_query(16'hfffe, 1'b1, 1'b0, '1, '1));
      directed.push_back(mk_query(16'h5a5a, 1'b1, 1'b0, {8'd9, 8'd10, 8'd99, 8'd100, 32'h0},
                                  64'h0));
      directed.push_back(mk_query(16'ha5a5, 1'b0, 1'b0, {8'd199, 8'd200, 8'd1, 8'd0,
                                  32'hffffffff}, '1));
      directed.push_back(mk_query(16'h0100, 1'b1, 1'b0, {8'd10, 8'd0, 8'd0, 8'd0, 32'h0},
                                  64'h0));
      directed.push_back(mk_query(16'h0200, 1'b0, 1'b0, {8'd1, 8'd2, 8'd3, 8'd100,
                                  32'h12345678}, 64'h0));
      directed.push_back(mk_query(16'h0300, 1'b1, 1'b0, {8'd100, 8'd10, 8'd1, 8'd255,
                                  32'h0}, 64'h0));
      directed.push_back(mk_query(16'h7f00, 1'b0, 1'b0, {8'd127, 8'd0, 8'd0, 8'd1,
                                  32'h0}, 64'h0));
      directed.push_back(mk_query(16'hc0a8, 1'b1, 1'b0, {8'd192, 8'd168, 8'd1, 8'd1,
                                  32'hdeadbeef}, 64'hcafef00d12345678));
      directed.push_back(mk_query(16'h0808, 1'b1, 1'b0, {8'd8, 8'd8, 8'd4, 8'd4, 32'h0},
                                  64'h0));
      directed.push_back(mk_query(16'h6363, 1'b0, 1'b0, {8'd99, 8'd99, 8'd99, 8'd9,
                                  32'h0}, 64'h0));
      directed.push_back(mk_query(16'h8000, 1'b0, 1'b0, {8'd200, 8'd250, 8'd10, 8'd1,
                                  32'h55aa55aa}, 64'haa55aa55aa55aa55));
      directed.push_back(mk_query(16'h4000, 1'b0, 1'b1, 64'h0, '1));
      foreach (directed[i]) offer_query(directed[i]);
      wait_for_drain();

      // random part, idle level changes every 25 requests
      random_count = QUERY_COUNT - directed.size();
      for (int k = 0; k < random_count; k++) begin
         if (k % 25 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 10;
               default: idle_pct = 35;
            endcase
         end
         if (k == random_count / 2) wait_for_drain();
         if (k >= random_count - QUIET_TAIL) quiet_tail = 1'b1;
         offer_query(random_query());
      end
      req_tvalid <= 1'b0;

      // drain, then allow stray words to show up
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending_words.size() != 0)
         sb.report($sformatf("%0d predicted words never arrived", sb.pending_words.size()));
      if (sb.mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Result side: check each word, stall in bursts, hold off once for a long stretch
   initial begin : response_side
      int stall_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && queries_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves on either side for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule
